/* rtl/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, operation and status codes, and the node record type.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int TOL_W         = 16;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
	} node_t;

endpackage

/* rtl/pli_in_if.sv */
// ----------------------------------------------------------------------------
// pli_in_if
// Input channel: operation code and node or query coordinates.
// ----------------------------------------------------------------------------
interface pli_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] x_value;
	logic [31:0] y_value;

	modport source (output valid, output op, output x_value, output y_value, input ready);
	modport sink   (input valid, input op, input x_value, input y_value, output ready);
endinterface

/* rtl/pli_out_if.sv */
// ----------------------------------------------------------------------------
// pli_out_if
// Result channel: interpolated value, status and node count.
// ----------------------------------------------------------------------------
interface pli_out_if #(
	parameter int CNT_W = 7
);
	logic             valid;
	logic             ready;
	logic [31:0]      result_value;
	logic [1:0]       status;
	logic [CNT_W-1:0] stored_nodes;

	modport source (output valid, output result_value, output status, output stored_nodes,
		input ready);
	modport sink   (input valid, input result_value, input status, input stored_nodes,
		output ready);
endinterface

/* rtl/pli_node_ram.sv */
// ----------------------------------------------------------------------------
// pli_node_ram
// Node table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pli_node_ram #(
	parameter int DEPTH = pli_pkg::MAX_NODES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  pli_pkg::node_t      wdata,
	input  logic [AW-1:0]       raddr,
	output pli_pkg::node_t      rdata
);

	pli_pkg::node_t mem [DEPTH];
	pli_pkg::node_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/pli_arith.sv */
// ----------------------------------------------------------------------------
// pli_arith
// Slope division, scaling multiply and saturating sum, one bit per cycle.
// ----------------------------------------------------------------------------
module pli_arith #(
	parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] dy,
	input  logic [31:0]        dx,
	input  logic [31:0]        t,
	input  logic [31:0]        y0,
	output logic               done,
	output logic [31:0]        result
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam int SW = NW - FRAC_BITS + 1;

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_DIV  = 3'd1;
	localparam logic [2:0] A_MUL  = 3'd2;
	localparam logic [2:0] A_SUM  = 3'd3;
	localparam logic [2:0] A_SAT  = 3'd4;

	logic [2:0]         ast_q;
	logic [CW-1:0]      cnt_q;
	logic               neg_q;
	logic [NW-1:0]      dvd_q;
	logic [31:0]        rem_q;
	logic [31:0]        dx_q;
	logic [31:0]        t_q;
	logic [NW-1:0]      acc_q;
	logic [31:0]        y0_q;
	logic signed [SW:0] sum_q;
	logic [31:0]        res_q;
	logic               done_q;

	logic [32:0]        rsh_w;
	logic               ge_w;
	logic [32:0]        rnext_w;
	logic [32:0]        mag_w;
	logic signed [NW:0] p_w;
	logic signed [NW:0] sh_w;
	logic signed [SW:0] sum_w;

	always_comb begin
		rsh_w   = {rem_q, dvd_q[NW-1]};
		ge_w    = rsh_w >= {1'b0, dx_q};
		rnext_w = ge_w ? rsh_w - {1'b0, dx_q} : rsh_w;
		mag_w   = dy[32] ? 33'(-dy) : 33'(dy);
		p_w     = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
		sh_w    = p_w >>> FRAC_BITS;
		sum_w   = $signed({sh_w[SW-1], sh_w[SW-1:0]}) + $signed({{(SW-31){y0_q[31]}}, y0_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ast_q  <= A_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ast_q)
				A_IDLE: begin
					if (start) begin
						ast_q <= A_DIV;
						cnt_q <= CW'(NW);
					end
				end
				A_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						ast_q <= A_MUL;
						cnt_q <= CW'(32);
					end
				end
				A_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						ast_q <= A_SUM;
					end
				end
				A_SUM: begin
					ast_q <= A_SAT;
				end
				A_SAT: begin
					ast_q  <= A_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					ast_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ast_q)
			A_IDLE: begin
				if (start) begin
					neg_q <= dy[32];
					dvd_q <= {mag_w[31:0], {FRAC_BITS{1'b0}}};
					rem_q <= '0;
					dx_q  <= dx;
					t_q   <= t;
					y0_q  <= y0;
					acc_q <= '0;
				end
			end
			A_DIV: begin
				rem_q <= rnext_w[31:0];
				dvd_q <= {dvd_q[NW-2:0], ge_w};
			end
			A_MUL: begin
				acc_q <= {acc_q[NW-2:0], 1'b0} + (t_q[31] ? dvd_q : '0);
				t_q   <= {t_q[30:0], 1'b0};
			end
			A_SUM: begin
				sum_q <= sum_w;
			end
			A_SAT: begin
				if (sum_q[SW:31] == '0 || sum_q[SW:31] == '1) begin
					res_q <= sum_q[31:0];
				end else if (sum_q[SW]) begin
					res_q <= 32'h8000_0000;
				end else begin
					res_q <= 32'h7FFF_FFFF;
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ast_q == A_IDLE) else $error("arith started while busy");
	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(ast_q == A_DIV && cnt_q == CW'(1)) |=> ast_q == A_MUL)
		else $error("division did not hand over to multiply");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ast_q) == A_SAT) else $error("done without saturate step");

endmodule

/* rtl/piecewise_linear_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit
// Sorted node table with linear interpolation between neighboring nodes.
//
//   channel     dir  kind              transaction
//   item_in     in   valid/ready       op, x_value, y_value
//   result_out  out  valid/ready       result_value, status, stored_nodes
//   cfg         in   write enable      duplicate_tolerance
//
// Clear and unused op go straight to the finish state. Load walks the table
// from the top through the node memory, reading and checking each stored node.
// Query scans the nodes and, on a hit, runs the serial division and multiply
// in the arithmetic unit.
// Reset clears the node count, invalid flag and tolerance (to 1).
// A finished result waits in the output register; the next transaction is
// accepted meanwhile and only its own result stalls on a busy output.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_unit #(
	parameter int MAX_NODES = pli_pkg::MAX_NODES_DEF,
	parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pli_in_if.sink                     item_in,
	pli_out_if.source                  result_out,
	input  logic                       cfg_we,
	input  logic [pli_pkg::TOL_W-1:0]  cfg_wdata
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LRD  = 3'd1;
	localparam logic [2:0] S_LCK  = 3'd2;
	localparam logic [2:0] S_LWR  = 3'd3;
	localparam logic [2:0] S_QRD  = 3'd4;
	localparam logic [2:0] S_QCK  = 3'd5;
	localparam logic [2:0] S_ARI  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0]                 st_q;
	logic [1:0]                 op_q;
	logic [31:0]                x_q;
	logic [31:0]                y_q;
	logic [CW-1:0]              cnt_q;
	logic                       flag_q;
	logic [pli_pkg::TOL_W-1:0]  tol_q;
	logic [AW-1:0]              idx_q;
	logic                       placed_q;
	pli_pkg::node_t             prev_q;
	logic [31:0]                res_q;
	logic [1:0]                 stat_q;
	logic                       out_valid_q;
	logic [31:0]                out_res_q;
	logic [1:0]                 out_stat_q;
	logic [CW-1:0]              out_cnt_q;

	pli_pkg::node_t             rd_w;
	pli_pkg::node_t             wdata_w;
	logic                       we_w;
	logic [AW-1:0]              waddr_w;
	logic                       accept_w;
	logic signed [32:0]         dist_w;
	logic [32:0]                adist_w;
	logic                       dup_w;
	logic                       above_w;
	logic                       hit_w;
	logic                       last_w;
	logic                       start_w;
	logic signed [32:0]         dy_w;
	logic                       ari_done_w;
	logic [31:0]                ari_res_w;
	logic                       out_free_w;

	assign accept_w   = item_in.valid && item_in.ready;
	assign out_free_w = !out_valid_q || result_out.ready;

	always_comb begin
		dist_w  = $signed({rd_w.x[31], rd_w.x}) - $signed({x_q[31], x_q});
		adist_w = dist_w[32] ? 33'(-dist_w) : 33'(dist_w);
		dup_w   = adist_w < {17'b0, tol_q};
		above_w = $signed(rd_w.x) > $signed(x_q);
		hit_w   = ($signed(x_q) >= $signed(prev_q.x)) && ($signed(x_q) < $signed(rd_w.x));
		last_w  = {{(CW-AW){1'b0}}, idx_q} == cnt_q - 1'b1;
		start_w = (st_q == S_QCK) && (idx_q != '0) && hit_w;
		dy_w    = $signed({rd_w.y[31], rd_w.y}) - $signed({prev_q.y[31], prev_q.y});
	end

	always_comb begin
		we_w    = 1'b0;
		waddr_w = '0;
		wdata_w = rd_w;
		if (st_q == S_LCK && !placed_q) begin
			we_w    = 1'b1;
			waddr_w = idx_q + AW'(1);
			wdata_w = above_w ? rd_w : pli_pkg::node_t'({x_q, y_q});
		end else if (st_q == S_LWR) begin
			we_w    = 1'b1;
			wdata_w = pli_pkg::node_t'({x_q, y_q});
		end
	end

	pli_node_ram #(
		.DEPTH (MAX_NODES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we_w),
		.waddr (waddr_w),
		.wdata (wdata_w),
		.raddr (idx_q),
		.rdata (rd_w)
	);

	pli_arith #(
		.FRAC_BITS (FRAC_BITS)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_w),
		.dy     (dy_w),
		.dx     (rd_w.x - prev_q.x),
		.t      (x_q - prev_q.x),
		.y0     (prev_q.y),
		.done   (ari_done_w),
		.result (ari_res_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= pli_pkg::TOL_W'(1);
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			cnt_q    <= '0;
			flag_q   <= 1'b0;
			idx_q    <= '0;
			placed_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept_w) begin
						st_q <= S_FIN;
						unique case (item_in.op)
							pli_pkg::OP_CLEAR: begin
								cnt_q  <= '0;
								flag_q <= 1'b0;
							end
							pli_pkg::OP_LOAD: begin
								if (cnt_q == CW'(MAX_NODES)) begin
									st_q <= S_FIN;
								end else if (cnt_q == '0) begin
									st_q <= S_LWR;
								end else begin
									idx_q    <= AW'(cnt_q - 1'b1);
									placed_q <= 1'b0;
									st_q     <= S_LRD;
								end
							end
							pli_pkg::OP_QUERY: begin
								if (!flag_q && cnt_q >= CW'(2)) begin
									idx_q <= '0;
									st_q  <= S_QRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_LRD: begin
					st_q <= S_LCK;
				end
				S_LCK: begin
					if (dup_w) begin
						flag_q <= 1'b1;
					end
					if (!placed_q && !above_w) begin
						placed_q <= 1'b1;
					end
					if (idx_q == '0) begin
						if (placed_q || !above_w) begin
							cnt_q <= cnt_q + 1'b1;
							st_q  <= S_FIN;
						end else begin
							st_q <= S_LWR;
						end
					end else begin
						idx_q <= idx_q - 1'b1;
						st_q  <= S_LRD;
					end
				end
				S_LWR: begin
					cnt_q <= cnt_q + 1'b1;
					st_q  <= S_FIN;
				end
				S_QRD: begin
					st_q <= S_QCK;
				end
				S_QCK: begin
					if (idx_q == '0) begin
						idx_q <= AW'(1);
						st_q  <= S_QRD;
					end else if (hit_w) begin
						st_q <= S_ARI;
					end else if (last_w) begin
						st_q <= S_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= S_QRD;
					end
				end
				S_ARI: begin
					if (ari_done_w) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free_w) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				if (accept_w) begin
					op_q   <= item_in.op;
					x_q    <= item_in.x_value;
					y_q    <= item_in.y_value;
					res_q  <= '0;
					stat_q <= pli_pkg::ST_OK;
					if (item_in.op == pli_pkg::OP_LOAD && cnt_q == CW'(MAX_NODES)) begin
						stat_q <= pli_pkg::ST_FULL;
					end else if (item_in.op == pli_pkg::OP_QUERY) begin
						if (flag_q) begin
							stat_q <= pli_pkg::ST_INVALID;
						end else if (cnt_q < CW'(2)) begin
							stat_q <= pli_pkg::ST_RANGE;
						end
					end
				end
			end
			S_LCK: begin
				stat_q <= (flag_q || dup_w) ? pli_pkg::ST_INVALID : pli_pkg::ST_OK;
			end
			S_LWR: begin
				stat_q <= flag_q ? pli_pkg::ST_INVALID : pli_pkg::ST_OK;
			end
			S_QCK: begin
				if (idx_q == '0 || !hit_w) begin
					prev_q <= rd_w;
				end
				if (idx_q != '0 && !hit_w && last_w) begin
					if (x_q == rd_w.x) begin
						res_q  <= rd_w.y;
						stat_q <= pli_pkg::ST_OK;
					end else begin
						stat_q <= pli_pkg::ST_RANGE;
					end
				end
			end
			S_ARI: begin
				if (ari_done_w) begin
					res_q  <= ari_res_w;
					stat_q <= pli_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == S_FIN && out_free_w) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_FIN && out_free_w) begin
			out_res_q  <= (op_q == pli_pkg::OP_QUERY) ? res_q : '0;
			out_stat_q <= stat_q;
			out_cnt_q  <= cnt_q;
		end
	end

	assign item_in.ready           = st_q == S_IDLE;
	assign result_out.valid        = out_valid_q;
	assign result_out.result_value = out_res_q;
	assign result_out.status       = out_stat_q;
	assign result_out.stored_nodes = out_cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_NODES)) else $error("node count beyond table depth");
	a_no_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_LCK || st_q == S_LWR) |-> cnt_q < CW'(MAX_NODES))
		else $error("insertion into a full table");
	a_start_to_ari: assert property (@(posedge clk) disable iff (!arst_n)
		start_w |=> st_q == S_ARI) else $error("arith start without wait state");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN && out_valid_q && !result_out.ready) |=> st_q == S_FIN)
		else $error("result overwrote a pending transaction");

endmodule
